[rtl/core/artdmx_pkg.sv]
// Package for the Art-Net DMX to RGB pixel block.
// Holds shared constants, result and configuration structs, and the header table.
// No dependencies.
package artdmx_pkg;

  localparam int MAX_LEDS = 256;

  localparam int ADDR_W = 3;
  localparam logic REG_UNIVERSE  = 1'b0;
  localparam logic REG_LED_COUNT = 1'b1;

  localparam logic [15:0] POS_OPCODE_LO = 16'd8;
  localparam logic [15:0] POS_OPCODE_HI = 16'd9;
  localparam logic [15:0] POS_UNIV_LO   = 16'd14;
  localparam logic [15:0] POS_UNIV_HI   = 16'd15;
  localparam logic [15:0] POS_COUNT_HI  = 16'd16;
  localparam logic [15:0] POS_COUNT_LO  = 16'd17;
  localparam logic [15:0] DATA_START    = 16'd18;

  localparam logic [7:0] OPCODE_LO = 8'h00;
  localparam logic [7:0] OPCODE_HI = 8'h50;

  typedef enum logic [1:0] {
    PH_RED   = 2'd0,
    PH_GREEN = 2'd1,
    PH_BLUE  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [15:0] universe;
    logic [8:0]  led_count;
  } cfg_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [7:0]  led_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        frame_end;
    logic [31:0] accepted_packets;
  } result_t;

  // "Art-Net" followed by a zero byte
  function automatic logic [7:0] art_id_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h41;
      3'd1:    b = 8'h72;
      3'd2:    b = 8'h74;
      3'd3:    b = 8'h2D;
      3'd4:    b = 8'h4E;
      3'd5:    b = 8'h65;
      3'd6:    b = 8'h74;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[rtl/core/artnet_dmx_to_rgb_pixels_top.sv]
// Channel    | Handshake          | Payload
// in         | in_valid/in_stall  | data_byte, end_of_packet
// out        | out_valid/out_stall| pixel_valid, led_index, red, green, blue,
//            |                    | frame_end, accepted_packets
// cfg        | APB psel/penable   | paddr, pwdata, prdata (universe @0, led_count @4)
//
// One byte per cycle unless in_stall; results are registered at the outputs.
// The rate is set by the single parser pass between state and result register.
// Synchronous active-high reset clears parser, config and buffer valid state.
// in_stall rises only when the result register and skid entry are both full.
// Top level of the Art-Net DMX to RGB pixel block; depends on artdmx_pkg,
// artdmx_cfg, artdmx_parser and artdmx_out_buf.
module artnet_dmx_to_rgb_pixels_top import artdmx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              end_of_packet,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              pixel_valid,
  output logic [7:0]        led_index,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue,
  output logic              frame_end,
  output logic [31:0]       accepted_packets,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t    cfg;
  logic    take;
  logic    res_valid;
  result_t res;
  result_t out_data;
  logic    full;

  assign in_stall = full;
  assign take     = in_valid && !full;

  artdmx_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  artdmx_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (data_byte),
    .end_of_packet (end_of_packet),
    .cfg           (cfg),
    .res_valid     (res_valid),
    .res           (res)
  );

  artdmx_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign pixel_valid      = out_data.pixel_valid;
  assign led_index        = out_data.led_index;
  assign red              = out_data.red;
  assign green            = out_data.green;
  assign blue             = out_data.blue;
  assign frame_end        = out_data.frame_end;
  assign accepted_packets = out_data.accepted_packets;

endmodule

[rtl/core/artdmx_cfg.sv]
// APB-style configuration registers: universe and LED count.
// Depends on artdmx_pkg.
module artdmx_cfg import artdmx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.universe  <= '0;
      cfg.led_count <= '0;
    end else if (wr) begin
      if (paddr[2] == REG_UNIVERSE) begin
        cfg.universe <= pwdata[15:0];
      end else begin
        cfg.led_count <= pwdata[8:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_LED_COUNT) begin
      prdata = {23'd0, cfg.led_count};
    end else begin
      prdata = {16'd0, cfg.universe};
    end
  end

endmodule

[rtl/core/artdmx_parser.sv]
// Per-byte Art-Net OpDmx parser: header checks, universe match, RGB grouping.
// Depends on artdmx_pkg. Produces at most one result per accepted byte.
module artdmx_parser import artdmx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       end_of_packet,
  input  cfg_t       cfg,
  output logic       res_valid,
  output result_t    res
);

  localparam logic [15:0] MaxLeds16 = 16'(MAX_LEDS);

  logic [15:0] byte_position, byte_position_next;
  logic        packet_ok, packet_ok_next;
  logic [7:0]  universe_low_hold, universe_low_hold_next;
  logic [15:0] channel_count, channel_count_next;
  phase_t      color_phase, color_phase_next;
  logic [7:0]  held_red, held_red_next;
  logic [7:0]  held_green, held_green_next;
  logic [15:0] pixel_counter, pixel_counter_next;
  logic [31:0] packet_counter, packet_counter_next;

  logic        fail;
  logic        pix;
  logic        fend;
  logic [17:0] triple_end;
  logic [15:0] limit;
  logic [15:0] pos;

  always_comb begin
    pos = byte_position;
    byte_position_next     = (pos == 16'hFFFF) ? pos : pos + 16'd1;
    universe_low_hold_next = universe_low_hold;
    channel_count_next     = channel_count;
    color_phase_next       = color_phase;
    held_red_next          = held_red;
    held_green_next        = held_green;
    pixel_counter_next     = pixel_counter;
    packet_counter_next    = packet_counter;
    fail = 1'b0;
    pix  = 1'b0;

    limit = ({7'd0, cfg.led_count} > MaxLeds16) ? MaxLeds16 : {7'd0, cfg.led_count};
    triple_end = {2'd0, pixel_counter} + {1'b0, pixel_counter, 1'b0} + 18'd3;

    if (pos[15:3] == 13'd0) begin
      fail = (data_byte != art_id_byte(pos[2:0]));
    end else if (pos == POS_OPCODE_LO) begin
      fail = (data_byte != OPCODE_LO);
    end else if (pos == POS_OPCODE_HI) begin
      fail = (data_byte != OPCODE_HI);
    end else if (pos == POS_UNIV_LO) begin
      universe_low_hold_next = data_byte;
    end else if (pos == POS_UNIV_HI) begin
      fail = ({data_byte, universe_low_hold} != cfg.universe);
    end else if (pos == POS_COUNT_HI) begin
      channel_count_next = {data_byte, 8'd0};
    end else if (pos == POS_COUNT_LO) begin
      channel_count_next = {channel_count[15:8], data_byte};
    end else if (pos >= DATA_START) begin
      case (color_phase)
        PH_RED: begin
          held_red_next    = data_byte;
          color_phase_next = PH_GREEN;
        end
        PH_GREEN: begin
          held_green_next  = data_byte;
          color_phase_next = PH_BLUE;
        end
        default: begin
          pix = packet_ok && (triple_end <= {2'd0, channel_count}) &&
                (pixel_counter < limit);
          if (pixel_counter != 16'hFFFF) begin
            pixel_counter_next = pixel_counter + 16'd1;
          end
          color_phase_next = PH_RED;
        end
      endcase
    end

    packet_ok_next = packet_ok && !fail;
    fend = end_of_packet && packet_ok_next && (pos >= POS_COUNT_LO);
    if (fend) begin
      packet_counter_next = packet_counter + 32'd1;
    end

    // end of packet: per-packet state back to reset
    if (end_of_packet) begin
      byte_position_next     = '0;
      packet_ok_next         = 1'b1;
      universe_low_hold_next = '0;
      channel_count_next     = '0;
      color_phase_next       = PH_RED;
      held_red_next          = '0;
      held_green_next        = '0;
      pixel_counter_next     = '0;
    end

    res_valid            = take && (pix || fend);
    res.pixel_valid      = pix;
    res.led_index        = pix ? pixel_counter[7:0] : 8'd0;
    res.red              = pix ? held_red : 8'd0;
    res.green            = pix ? held_green : 8'd0;
    res.blue             = pix ? data_byte : 8'd0;
    res.frame_end        = fend;
    res.accepted_packets = fend ? packet_counter_next : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      packet_ok         <= 1'b1;
      universe_low_hold <= '0;
      channel_count     <= '0;
      color_phase       <= PH_RED;
      held_red          <= '0;
      held_green        <= '0;
      pixel_counter     <= '0;
      packet_counter    <= '0;
    end else if (take) begin
      byte_position     <= byte_position_next;
      packet_ok         <= packet_ok_next;
      universe_low_hold <= universe_low_hold_next;
      channel_count     <= channel_count_next;
      color_phase       <= color_phase_next;
      held_red          <= held_red_next;
      held_green        <= held_green_next;
      pixel_counter     <= pixel_counter_next;
      packet_counter    <= packet_counter_next;
    end
  end

endmodule

[rtl/core/artdmx_out_buf.sv]
// Result register with a skid entry that holds one result pushed during a stall.
// Depends on artdmx_pkg.
module artdmx_out_buf import artdmx_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    valid_r;
  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop       = valid_r && !out_stall;
  assign out_valid = valid_r;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_r    <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!valid_r || pop) begin
      valid_r    <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!valid_r || pop) begin
      out_data <= skid_valid ? skid_data : push_data;
    end
    if (valid_r && !pop && push) begin
      skid_data <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> valid_r)
    else $error("skid entry held with empty output register");

  a_stalled_push_kept: assert property (@(posedge clk) disable iff (rst)
    (valid_r && out_stall && push) |=> skid_valid)
    else $error("result pushed during stall was not kept in skid");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> (valid_r && !skid_valid))
    else $error("skid entry did not move to output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("push while skid entry occupied");
`endif

endmodule
